### rtl/core/fkmp_pkg.sv
// Shared types, codes and keyword tables for the framed keyword message parser.
package fkmp_pkg;

  // Width of one received byte and of the packed data buses.
  localparam int unsigned BYTE_W = 8;
  // Width of the configuration register index.
  localparam int unsigned CFG_INDEX_W = 2;
  // Number of keywords matched in parallel.
  localparam int unsigned KW_COUNT = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_START_CHAR = 2'd0,
    REG_END_CHAR   = 2'd1
  } cfg_reg_t;

  // Result codes; the first four follow the keyword order.
  typedef enum logic [2:0] {
    KIND_CONNECTED    = 3'd0,
    KIND_DISCONNECTED = 3'd1,
    KIND_SCAN_BEGUN   = 3'd2,
    KIND_SCAN_HALTED  = 3'd3,
    KIND_UNRECOGNIZED = 3'd4,
    KIND_OVERRUN      = 3'd5
  } kind_t;

  // Reset values of the frame delimiters.
  localparam logic [BYTE_W-1:0] START_CHAR_RESET = 8'h21;
  localparam logic [BYTE_W-1:0] END_CHAR_RESET   = 8'h3B;

  // Length of keyword k.
  function automatic logic [7:0] kw_len(input logic [1:0] k);
    logic [7:0] len;
    case (k)
      2'd0:    len = 8'd1;
      2'd1:    len = 8'd1;
      2'd2:    len = 8'd10;
      default: len = 8'd9;
    endcase
    return len;
  endfunction

  // Character of keyword k at position pos, zero past the keyword's end.
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [7:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: begin
        if (pos == 8'd0) c = "C";
      end
      2'd1: begin
        if (pos == 8'd0) c = "D";
      end
      2'd2: begin
        case (pos)
          8'd0: c = "S";
          8'd1: c = "C";
          8'd2: c = "A";
          8'd3: c = "N";
          8'd4: c = "_";
          8'd5: c = "S";
          8'd6: c = "T";
          8'd7: c = "A";
          8'd8: c = "R";
          8'd9: c = "T";
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          8'd0: c = "S";
          8'd1: c = "C";
          8'd2: c = "A";
          8'd3: c = "N";
          8'd4: c = "_";
          8'd5: c = "S";
          8'd6: c = "T";
          8'd7: c = "O";
          8'd8: c = "P";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

### rtl/core/framed_keyword_message_parser_unit.sv
// Framed keyword message parser: byte stream in, one message kind per closed frame out.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry received bytes, one byte per transfer.
//   m_tvalid/m_tready/m_tdata carry results; m_tdata[2:0] is the message kind
//   (0 connected, 1 disconnected, 2 scan started, 3 scan stopped,
//   4 unrecognized, 5 overrun).
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the start character (index 0)
//   and the end character (index 1); other indexes are dropped. cfg_ready is
//   always high. Write the registers only while no byte is in flight.
// Timing:
//   Each byte is handled in the cycle it is transferred; the frame state and
//   the result register update at that edge, so a result appears on m_tvalid
//   in the cycle after the closing or overflowing byte. One byte is taken every
//   cycle; the single result register is the only limit.
// Reset and stalls:
//   rst (synchronous, active high) closes any open frame, restores the default
//   delimiters and empties the result register. While a result waits and
//   m_tready is low, s_tready drops; bytes that would produce no result still
//   wait, and the byte stream resumes as soon as the result is transferred.
module framed_keyword_message_parser_unit
  import fkmp_pkg::*;
#(
  parameter int unsigned MAX_BODY_LEN = 100
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input byte stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [BYTE_W-1:0]      m_tdata,   // [2:0] message_kind, [7:3] zero
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data
);

  localparam int unsigned LEN_W = $clog2(MAX_BODY_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_BODY_LEN);

  // Configuration registers.
  logic [BYTE_W-1:0] start_char;
  logic [BYTE_W-1:0] end_char;

  // Frame state.
  logic                in_frame;
  logic                in_frame_next;
  logic [LEN_W-1:0]    body_length;
  logic [LEN_W-1:0]    body_length_next;
  logic [KW_COUNT-1:0] kw_possible;
  logic [KW_COUNT-1:0] kw_possible_next;
  logic                body_terminated;
  logic                body_terminated_next;

  // Result register.
  logic  out_valid;
  kind_t out_kind;

  // Per-byte decisions.
  logic                s_fire;
  logic                res_valid;
  kind_t               res_kind;
  logic [KW_COUNT-1:0] kw_keep;
  logic [KW_COUNT-1:0] kw_done;
  logic [LEN_W-1:0]    len_inc;
  logic                match_found;

  assign cfg_ready = 1'b1;
  assign s_tready  = !out_valid || m_tready;
  assign s_fire    = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {{(BYTE_W - 3){1'b0}}, out_kind};
  assign len_inc   = body_length + LEN_W'(1);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_char <= START_CHAR_RESET;
      end_char   <= END_CHAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_START_CHAR: start_char <= cfg_data;
        REG_END_CHAR:   end_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Keyword candidates that survive the current byte at the current position,
  // and still possible keywords whose full length equals the current body length or whose body ended in a zero byte.
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      if (s_tdata == '0) begin
        kw_keep[k] = (kw_len(2'(k)) == 8'(body_length));
      end else begin
        kw_keep[k] = (kw_char(2'(k), 8'(body_length)) == s_tdata);
      end
      kw_done[k] = kw_possible[k] && (body_terminated || kw_len(2'(k)) == 8'(body_length));
    end
  end

  // Next frame state and the result for one transferred byte.
  always_comb begin
    in_frame_next        = in_frame;
    body_length_next     = body_length;
    kw_possible_next     = kw_possible;
    body_terminated_next = body_terminated;
    res_valid            = 1'b0;
    res_kind             = KIND_UNRECOGNIZED;
    match_found          = 1'b0;

    if (!in_frame) begin
      if (s_tdata == start_char) begin
        in_frame_next        = 1'b1;
        body_length_next     = '0;
        kw_possible_next     = '1;
        body_terminated_next = 1'b0;
      end
    end else if (s_tdata == end_char) begin
      // Close the frame and report the first keyword that fits.
      in_frame_next = 1'b0;
      res_valid     = 1'b1;
      for (int k = 0; k < KW_COUNT; k++) begin
        if (kw_done[k] && !match_found) begin
          match_found = 1'b1;
          res_kind    = kind_t'(3'(k));
        end
      end
    end else begin
      // Store the byte; matching stops after the first zero byte.
      if (!body_terminated) begin
        kw_possible_next = kw_possible & kw_keep;
        if (s_tdata == '0) begin
          body_terminated_next = 1'b1;
        end
      end
      body_length_next = len_inc;
      if (len_inc >= LEN_LIMIT) begin
        in_frame_next = 1'b0;
        res_valid     = 1'b1;
        res_kind      = KIND_OVERRUN;
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame        <= 1'b0;
      body_length     <= '0;
      kw_possible     <= '1;
      body_terminated <= 1'b0;
    end else if (s_fire) begin
      in_frame        <= in_frame_next;
      body_length     <= body_length_next;
      kw_possible     <= kw_possible_next;
      body_terminated <= body_terminated_next;
    end
  end

  // Result register: loads on a byte that yields a result, empties on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && res_valid) begin
      out_kind <= res_kind;
    end
  end

  // An open frame never holds a body at or beyond the length limit.
  assert property (@(posedge clk) disable iff (rst) in_frame |-> body_length < LEN_LIMIT)
    else $error("body length reached the limit without closing the frame");

  // A zero byte is always counted, so a terminated body is never empty.
  assert property (@(posedge clk) disable iff (rst) body_terminated |-> body_length != '0)
    else $error("terminated body with zero length");

  // A stored byte that reaches the limit closes the frame with an overrun result.
  assert property (@(posedge clk) disable iff (rst)
    (s_fire && in_frame && s_tdata != end_char && len_inc == LEN_LIMIT)
      |=> (!in_frame && out_valid && out_kind == KIND_OVERRUN))
    else $error("overrun did not close the frame");

  // Results only carry defined message kinds.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> out_kind <= KIND_OVERRUN)
    else $error("undefined message kind on the result stream");

endmodule

### verif/tb_framed_keyword_message_parser_unit.sv
// Testbench for the framed keyword message parser: directed and random framed byte streams checked against a predictor.
module tb_framed_keyword_message_parser_unit;
  import fkmp_pkg::*;

  localparam int unsigned MAX_BODY = 100;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  // Register indexes past the two delimiters; writes to them must be dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  // Tracks the frame state and the message kinds still owed by the block.
  class message_kind_predictor;
    logic [7:0] start_ch;
    logic [7:0] end_ch;
    bit in_frame;
    bit terminated;
    logic [6:0] body_len;
    logic [3:0] still_possible;
    int unsigned max_len;
    string keywords[4];
    kind_t keyword_kind[4];
    kind_t expected_kinds[$];
    int unsigned fault_count;

    function new(int unsigned body_limit);
      keywords[0] = "C";
      keywords[1] = "D";
      keywords[2] = {"SCAN_", "START"};
      keywords[3] = {"SCAN_", "STOP"};
      keyword_kind[0] = KIND_CONNECTED;
      keyword_kind[1] = KIND_DISCONNECTED;
      keyword_kind[2] = KIND_SCAN_BEGUN;
      keyword_kind[3] = KIND_SCAN_HALTED;
      max_len = body_limit;
      start_ch = START_CHAR_RESET;
      end_ch = END_CHAR_RESET;
      in_frame = 1'b0;
      fault_count = 0;
      open_body();
    endfunction

    function void open_body();
      body_len = '0;
      still_possible = '1;
      terminated = 1'b0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] data);
      if (idx == REG_START_CHAR) start_ch = data;
      else if (idx == REG_END_CHAR) end_ch = data;
    endfunction

    // Drop every keyword that no longer agrees with the byte at the current position.
    function void narrow(logic [7:0] b);
      logic [3:0] keep;
      int pos;
      if (terminated) return;
      keep = '0;
      pos = body_len;
      for (int k = 0; k < 4; k++) begin
        if (b == 8'h00) keep[k] = (keywords[k].len() == pos);
        else keep[k] = (pos < keywords[k].len()) && (keywords[k][pos] == b);
      end
      still_possible &= keep;
      if (b == 8'h00) terminated = 1'b1;
    endfunction

    // Called for every byte the block accepted.
    function void note_byte(logic [7:0] b);
      kind_t kind;
      bit found;
      if (!in_frame) begin
        if (b == start_ch) begin
          open_body();
          in_frame = 1'b1;
        end
        return;
      end
      if (b == end_ch) begin
        kind = KIND_UNRECOGNIZED;
        found = 1'b0;
        for (int k = 0; k < 4; k++) begin
          if (!found && still_possible[k] && (terminated || keywords[k].len() == body_len)) begin
            kind = keyword_kind[k];
            found = 1'b1;
          end
        end
        in_frame = 1'b0;
        expected_kinds.push_back(kind);
        return;
      end
      narrow(b);
      body_len++;
      if (body_len >= max_len) begin
        in_frame = 1'b0;
        expected_kinds.push_back(KIND_OVERRUN);
      end
    endfunction

    // Called for every result the block handed over.
    function void check_kind(logic [7:0] data);
      kind_t want;
      if (expected_kinds.size() == 0) begin
        fault_count++;
        $display("%0t: result with none expected, expected none, got 0x%02h", $time, data);
        return;
      end
      want = expected_kinds.pop_front();
      if (data !== {5'b00000, want}) begin
        fault_count++;
        $display("%0t: message kind mismatch, expected 0x%02h, got 0x%02h",
                 $time, {5'b00000, want}, data);
      end
    endfunction

    function int pending();
      return expected_kinds.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [BYTE_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [BYTE_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0] cfg_data = '0;

  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_req = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  message_kind_predictor kind_model = new(MAX_BODY);

  framed_keyword_message_parser_unit #(
    .MAX_BODY_LEN(MAX_BODY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        m_tready = 1'b1;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        m_tready = 1'b1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) kind_model.check_kind(m_tdata);
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Offer one byte, with an optional gap before it, and wait for its transfer.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    kind_model.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Body bytes lean toward keyword letters and the zero terminator.
  function automatic logic [7:0] pick_body_byte();
    string letters = "SCANTOPRD_";
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r < 5) return letters[$urandom_range(0, letters.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // One frame, possibly after some line noise: exact, damaged, random or long body.
  task automatic send_frame(input bit long_body);
    int sel;
    int k;
    int n;
    int len;
    int pos;
    int mode;
    string word;
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end
    sel = long_body ? 99 : $urandom_range(0, 99);
    k = $urandom_range(0, 3);
    word = kind_model.keywords[k];
    n = word.len();
    send_byte(kind_model.start_ch);
    if (sel < 40) begin
      send_text(word);
      if ($urandom_range(0, 3) == 0) begin
        send_byte(8'h00);
        repeat ($urandom_range(0, 3)) send_byte(pick_body_byte());
      end
    end else if (sel < 60) begin
      // Truncate, flip one bit of one letter, or append a nonzero byte.
      mode = $urandom_range(0, 2);
      pos = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) begin
        b = word[i];
        if (mode == 1 && i == pos) b = b ^ (8'h01 << $urandom_range(0, 7));
        if (!(mode == 0 && i >= pos)) send_byte(b);
      end
      if (mode == 2) send_byte(8'($urandom_range(1, 255)));
    end else if (sel < 98) begin
      len = $urandom_range(0, 24);
      repeat (len) send_byte(pick_body_byte());
    end else begin
      // Long body that ends just short of the length limit or runs into it.
      len = $urandom_range(MAX_BODY - 2, MAX_BODY + 10);
      for (int i = 0; i < len; i++) begin
        b = pick_body_byte();
        if (b == kind_model.end_ch) b = ~b;
        send_byte(b);
      end
    end
    send_byte(kind_model.end_ch);
  endtask

  // Stop offering bytes and let every owed result come out.
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (kind_model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    kind_model.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_delimiters(input logic [7:0] open_ch, input logic [7:0] close_ch);
    write_reg(REG_START_CHAR, open_ch);
    write_reg(REG_END_CHAR, close_ch);
  endtask

  task automatic run_phase(input int unsigned count, input bit idle);
    int unsigned target;
    tx_idle = idle;
    rx_idle = idle;
    target = bytes_sent + count;
    while (bytes_sent < target) send_frame(1'b0);
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed frames with the reset delimiters.
    send_byte(8'hFF);
    send_byte(";");
    send_text("!C;");
    send_text("!D;");
    send_text({"!SCAN_", "STOP;"});
    send_text("!;");
    send_text("!D");
    send_byte(8'h00);
    send_text("Z;");
    settle();

    // Writes to unused indexes must leave the delimiters alone.
    write_reg(REG_SPARE_2, 8'h43);
    write_reg(REG_SPARE_3, 8'h44);
    set_delimiters(START_CHAR_RESET, END_CHAR_RESET);

    // Long hold-off on the result side while bytes keep coming.
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 1'b1;
    send_frame(1'b1);
    run_phase(300, 1'b1);

    set_delimiters(8'h00, 8'hFF);
    run_phase(300, 1'b1);
    set_delimiters(8'hFF, 8'h00);
    run_phase(300, 1'b1);
    // The same byte both opens and closes a frame.
    set_delimiters(8'h7E, 8'h7E);
    run_phase(250, 1'b1);
    set_delimiters(";", "!");
    run_phase(250, 1'b1);
    // Final stretch runs at full rate on both sides.
    set_delimiters(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_phase(300, 1'b0);

    if (kind_model.fault_count == 0 && kind_model.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### framed_keyword_message_parser_unit.f
rtl/core/fkmp_pkg.sv
rtl/core/framed_keyword_message_parser_unit.sv
verif/tb_framed_keyword_message_parser_unit.sv
